// ----- rtl/core/plid_pkg.sv -----
package plid_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BOUND = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } plid_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] item;
    logic                    last;
  } plid_out_t;

endpackage

// ----- rtl/core/plid_ram.sv -----
module plid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/core/plid_ctrl.sv -----
module plid_ctrl
  import plid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  plid_in_t                    in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output plid_out_t                   out_data,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [VAL_W-1:0]            ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [VAL_W-1:0]            ram_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = POS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_CHK, S_INS_WR, S_DEL_CHK, S_DEL_WR, S_DMP_RD, S_DMP_OUT, S_RESP
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    tgt_r;
  logic [VAL_W-1:0] val_r;
  logic [1:0]       status_r;
  logic             out_valid_r;
  plid_out_t        out_data_r;

  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] ins_tgt;
  logic          full;
  logic          empty;
  logic          del_bad;
  logic          step_dec;
  logic [AW-1:0] step_c;
  logic          ins_hit;
  logic          seq_end;
  logic          out_free;
  logic          out_load;

  assign cnt_ext = PW'(count_r);
  assign pos_ext = PW'(in_data.position);
  assign pos_m1  = pos_ext - PW'(1);
  assign ins_tgt = (pos_ext == '0) ? '0 : ((pos_m1 > cnt_ext) ? cnt_ext : pos_m1);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign del_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

  assign step_dec = (state_r == S_INS_CHK) || (state_r == S_INS_WR);
  assign step_c   = step_dec ? (idx_r - AW'(1)) : (idx_r + AW'(1));
  assign ins_hit  = (idx_r == tgt_r);
  assign seq_end  = ((CW'(idx_r) + CW'(1)) == count_r);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ((state_r == S_DMP_OUT) || (state_r == S_RESP)) && out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = step_c;
    unique case (state_r)
      S_INS_CHK: begin
        if (ins_hit) begin
          ram_we    = 1'b1;
          ram_waddr = tgt_r;
          ram_wdata = val_r;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_INS_WR, S_DEL_WR: begin
        ram_we = 1'b1;
      end
      S_DEL_CHK: begin
        ram_re = !seq_end;
      end
      S_DMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.req_type)
              REQ_INSERT: begin
                if (full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_RESP;
                end else begin
                  tgt_r   <= ins_tgt[AW-1:0];
                  idx_r   <= count_r[AW-1:0];
                  val_r   <= in_data.value;
                  state_r <= S_INS_CHK;
                end
              end
              REQ_DELETE: begin
                if (empty) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_RESP;
                end else if (del_bad) begin
                  status_r <= ST_BOUND;
                  state_r  <= S_RESP;
                end else begin
                  idx_r   <= pos_m1[AW-1:0];
                  state_r <= S_DEL_CHK;
                end
              end
              REQ_DUMP: begin
                if (empty) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_RESP;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_DMP_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_CHK: begin
          if (ins_hit) begin
            count_r  <= count_r + CW'(1);
            status_r <= ST_OK;
            state_r  <= S_RESP;
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR, S_DEL_WR: begin
          idx_r   <= step_c;
          state_r <= (state_r == S_INS_WR) ? S_INS_CHK : S_DEL_CHK;
        end
        S_DEL_CHK: begin
          if (seq_end) begin
            count_r  <= count_r - CW'(1);
            status_r <= ST_OK;
            state_r  <= S_RESP;
          end else begin
            state_r <= S_DEL_WR;
          end
        end
        S_DMP_RD: begin
          state_r <= S_DMP_OUT;
        end
        S_DMP_OUT: begin
          if (out_free) begin
            out_data_r.status  <= ST_OK;
            out_data_r.item    <= ram_rdata;
            out_data_r.last    <= seq_end;
            if (seq_end) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= step_c;
              state_r <= S_DMP_RD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r.status <= status_r;
            out_data_r.item   <= '0;
            out_data_r.last   <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/positional_list_insert_delete.sv -----
// Ordered list of up to CAPACITY signed 32-bit values kept in a single-port-write RAM.
// The input channel (in_valid, in_ready, in_data) takes insert, delete and dump requests.
// The result channel (out_valid, out_ready, out_data) returns one transfer per insert or
// delete, and one transfer per stored value for a dump, with last set on the final one.
// A request is taken only while the sequencer is idle; in_ready is low while it works.
// Insert and delete shift the cells between the position and the end of the list: each
// shifted cell costs one RAM read and one RAM write through the shared index counter.
// A dump reads each value through the registered RAM read (S_DMP_RD) before it is
// loaded into the result register (S_DMP_OUT). A rejected request goes straight to S_RESP.
// The result register lets a new request be taken while the last result still waits.
// When the receiver stalls, the sequencer holds before loading the result register.
// Synchronous reset empties the list; the RAM contents are not cleared, since only
// cells below the current count are ever read.
module positional_list_insert_delete
  import plid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  plid_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output plid_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  plid_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  plid_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// ----- rtl/core/plid_chk.sv -----
module plid_chk
  import plid_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input plid_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input plid_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last && (out_data.item == '0))
    else $error("error result without last or with nonzero item");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_data.req_type == REQ_INSERT) ||
      (in_data.req_type == REQ_DELETE) || (in_data.req_type == REQ_DUMP)) |=> !in_ready)
    else $error("new request taken while previous one is in progress");

endmodule

bind positional_list_insert_delete plid_chk u_plid_chk (.*);

// ----- tb/tb_positional_list_insert_delete.sv -----
module tb_positional_list_insert_delete;
  import plid_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int PHASE_LEN = 34;
  localparam int PHASES = 11;
  localparam int BIAS_FILL = 0;
  localparam int BIAS_MIXED = 1;
  localparam int BIAS_DRAIN = 2;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  pos;
    logic [31:0] val;
    logic [5:0]  rep;
    logic        typed;
    logic [1:0]  st;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  plid_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  plid_out_t out_data;

  logic signed [31:0] list_cells [LIST_CAP];
  int                 list_len;
  plid_out_t          expected_results [$];
  plid_out_t          want;

  int errors;
  int n_requests, n_inserts, n_deletes, n_dumps, n_unused;
  int n_results, n_full, n_empty, n_bound;
  int send_idle_pct, recv_idle_pct;
  bit calm;

  stim_row_t directed_rows [25] = '{
    '{REQ_DUMP,   8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_EMPTY},
    '{REQ_DELETE, 8'd1,   32'h0000_0000, 6'd1,  1'b1, ST_EMPTY},
    '{REQ_DELETE, 8'd0,   32'hFFFF_FFFF, 6'd1,  1'b1, ST_EMPTY},
    '{REQ_UNUSED, 8'd255, 32'h1234_5678, 6'd1,  1'b0, ST_OK},
    '{REQ_INSERT, 8'd0,   32'h8000_0000, 6'd1,  1'b1, ST_OK},
    '{REQ_INSERT, 8'd255, 32'h7FFF_FFFF, 6'd1,  1'b1, ST_OK},
    '{REQ_INSERT, 8'd1,   32'hFFFF_FFFF, 6'd1,  1'b1, ST_OK},
    '{REQ_INSERT, 8'd2,   32'h0000_0000, 6'd1,  1'b1, ST_OK},
    '{REQ_INSERT, 8'd3,   32'h5555_AAAA, 6'd1,  1'b1, ST_OK},
    '{REQ_DUMP,   8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK},
    '{REQ_DELETE, 8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_BOUND},
    '{REQ_DELETE, 8'd255, 32'h0000_0000, 6'd1,  1'b1, ST_BOUND},
    '{REQ_DELETE, 8'd6,   32'h0000_0000, 6'd1,  1'b1, ST_BOUND},
    '{REQ_DELETE, 8'd5,   32'h0000_0000, 6'd1,  1'b1, ST_OK},
    '{REQ_DELETE, 8'd2,   32'h0000_0000, 6'd1,  1'b1, ST_OK},
    '{REQ_DELETE, 8'd1,   32'h0000_0000, 6'd1,  1'b1, ST_OK},
    '{REQ_DUMP,   8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK},
    '{REQ_INSERT, 8'hAA,  32'h0000_0000, 6'd30, 1'b1, ST_OK},
    '{REQ_INSERT, 8'd1,   32'hAAAA_5555, 6'd1,  1'b1, ST_FULL},
    '{REQ_INSERT, 8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_FULL},
    '{REQ_DUMP,   8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK},
    '{REQ_DELETE, 8'd33,  32'h0000_0000, 6'd1,  1'b1, ST_BOUND},
    '{REQ_DELETE, 8'd32,  32'h0000_0000, 6'd1,  1'b1, ST_OK},
    '{REQ_INSERT, 8'd255, 32'h0F0F_F0F0, 6'd1,  1'b1, ST_OK},
    '{REQ_UNUSED, 8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK}
  };

  positional_list_insert_delete dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL positional_list_insert_delete");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, exp_val);
    errors++;
  endtask

  function automatic void apply_request(input plid_in_t r, input bit keep);
    int p;
    plid_out_t res;
    res = '0;
    res.last = 1'b1;
    case (r.req_type)
      REQ_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          p = r.position;
          if (p < 1) p = 1;
          if (p > list_len + 1) p = list_len + 1;
          for (int i = list_len; i > p - 1; i--) list_cells[i] = list_cells[i-1];
          list_cells[p-1] = r.value;
          list_len++;
          res.status = ST_OK;
        end
        if (keep) expected_results.push_back(res);
      end
      REQ_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else if (r.position < 1 || r.position > list_len) begin
          res.status = ST_BOUND;
          n_bound++;
        end else begin
          for (int i = r.position - 1; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
          res.status = ST_OK;
        end
        if (keep) expected_results.push_back(res);
      end
      REQ_DUMP: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
          if (keep) expected_results.push_back(res);
        end else if (keep) begin
          for (int i = 0; i < list_len; i++) begin
            res.status = ST_OK;
            res.item = list_cells[i];
            res.last = (i == list_len - 1);
            expected_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input plid_in_t r, input bit typed, input logic [1:0] st);
    plid_out_t res;
    if (!calm && send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    n_requests++;
    case (r.req_type)
      REQ_INSERT: n_inserts++;
      REQ_DELETE: n_deletes++;
      REQ_DUMP:   n_dumps++;
      default:    n_unused++;
    endcase
    apply_request(r, !typed);
    if (typed) begin
      res = '0;
      res.status = st;
      res.last = 1'b1;
      expected_results.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic plid_in_t random_request(input int bias);
    plid_in_t r;
    int roll;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  r.req_type = roll < 85 ? REQ_INSERT : roll < 92 ? REQ_DELETE :
                               roll < 98 ? REQ_DUMP : REQ_UNUSED;
      BIAS_DRAIN: r.req_type = roll < 20 ? REQ_INSERT : roll < 85 ? REQ_DELETE :
                               roll < 97 ? REQ_DUMP : REQ_UNUSED;
      default:    r.req_type = roll < 45 ? REQ_INSERT : roll < 80 ? REQ_DELETE :
                               roll < 96 ? REQ_DUMP : REQ_UNUSED;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 10) r.position = '0;
    else if (roll < 25) r.position = $urandom_range(0, 255);
    else r.position = $urandom_range(1, list_len + 1);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: r.value = 32'h8000_0000;
        1: r.value = 32'h7FFF_FFFF;
        2: r.value = 32'h0000_0000;
        default: r.value = 32'hFFFF_FFFF;
      endcase
    end else begin
      r.value = $urandom;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.item, 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.item !== want.item)
          report_mismatch("item", out_data.item, want.item);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    plid_in_t r;
    int bias;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    list_len = 0;
    errors = 0;
    calm = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      for (int k = 0; k < directed_rows[n].rep; k++) begin
        r.req_type = directed_rows[n].req;
        r.position = directed_rows[n].pos;
        r.value = (directed_rows[n].rep > 1) ? $urandom : directed_rows[n].val;
        send_request(r, directed_rows[n].typed, directed_rows[n].st);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph % 3 == 1) drain_results();
      case (ph % 4)
        0: bias = BIAS_FILL;
        1: bias = BIAS_MIXED;
        2: bias = BIAS_DRAIN;
        default: bias = $urandom_range(BIAS_FILL, BIAS_DRAIN);
      endcase
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 15;
        default: recv_idle_pct = 40;
      endcase
      calm = (ph == PHASES - 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        r = random_request(bias);
        send_request(r, 1'b0, ST_OK);
      end
    end

    drain_results();
    repeat (200) @(posedge clk);

    $display("Sent %0d requests: %0d inserts, %0d deletes, %0d dumps, %0d unused codes.",
             n_requests, n_inserts, n_deletes, n_dumps, n_unused);
    $display("Checked %0d results, with %0d full, %0d empty and %0d out-of-bound answers.",
             n_results, n_full, n_empty, n_bound);
    if (errors == 0) begin
      $display("PASS positional_list_insert_delete");
    end else begin
      $display("FAIL positional_list_insert_delete");
    end
    $finish;
  end

endmodule
